// ===== src/jsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// jsrl_pkg
// Shared widths, codes and controller/datapath handshake types for the
// joint setpoint rate limiter.
// ----------------------------------------------------------------------------
package jsrl_pkg;

  localparam int JOINTS   = 7;
  localparam int JOINT_W  = 3;
  localparam int ANG_W    = 28;
  localparam int TICKS_W  = 10;
  localparam int MSTEP_W  = 25;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 25;

  // difference goal - measured and its magnitude
  localparam int DIFF_W   = ANG_W + 1;
  localparam int DIV_BITS = DIFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);
  // clamped step, |step| < 2^25
  localparam int STEP_W   = MSTEP_W + 1;

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(40);
  localparam logic [MSTEP_W-1:0] MSTEP_RESET = MSTEP_W'(16777);

  localparam logic [FUNC_W-1:0] FUNC_GOAL  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT       = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic clamp;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic launch;
    logic div_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== src/jsrl_in_if.sv =====
// ----------------------------------------------------------------------------
// jsrl_in_if
// Input item channel: goal values and tick measurements.
// ----------------------------------------------------------------------------
interface jsrl_in_if;
  logic                          valid;
  logic                          ready;
  logic [jsrl_pkg::FUNC_W-1:0]   func;
  logic [jsrl_pkg::JOINT_W-1:0]  joint;
  logic signed [jsrl_pkg::ANG_W-1:0] position;
  logic                          last_in_group;

  modport source (output valid, func, joint, position, last_in_group, input ready);
  modport sink   (input valid, func, joint, position, last_in_group, output ready);
endinterface

// ===== src/jsrl_out_if.sv =====
// ----------------------------------------------------------------------------
// jsrl_out_if
// Result channel: one new joint command per tick item for a joint in range.
// ----------------------------------------------------------------------------
interface jsrl_out_if;
  logic                          valid;
  logic                          ready;
  logic [jsrl_pkg::JOINT_W-1:0]  out_joint;
  logic signed [jsrl_pkg::ANG_W-1:0] command;
  logic                          tick_end;

  modport source (output valid, out_joint, command, tick_end, input ready);
  modport sink   (input valid, out_joint, command, tick_end, output ready);
endinterface

// ===== src/jsrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// jsrl_ctrl
// Sequencer: accept, bit-serial divide, clamp, apply and hand off result.
// ----------------------------------------------------------------------------
module jsrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jsrl_pkg::ctrl_sts_t   sts,
  output jsrl_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_CLAMP = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [jsrl_pkg::DIV_CNT_W-1:0] cnt, cnt_next;
  logic cnt_last;

  assign in_ready = (state == S_IDLE);
  assign cnt_last = (cnt == jsrl_pkg::DIV_CNT_W'(jsrl_pkg::DIV_BITS - 1));

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.clamp    = 1'b0;
    cmd.apply    = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        cnt_next = '0;
        if (in_valid && sts.launch) state_next = S_DIV;
      end
      S_DIV: begin
        // zero divisor: quotient register already holds |d|
        cmd.div_step = !sts.div_zero;
        cnt_next     = cnt + 1'b1;
        if (sts.div_zero || cnt_last) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== src/jsrl_datapath.sv =====
// ----------------------------------------------------------------------------
// jsrl_datapath
// Per-joint goal/command store, period bookkeeping, restoring divider,
// step clamp, saturating add and the output register.
// ----------------------------------------------------------------------------
module jsrl_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [jsrl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jsrl_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [jsrl_pkg::FUNC_W-1:0]           func,
  input  logic [jsrl_pkg::JOINT_W-1:0]          joint,
  input  logic signed [jsrl_pkg::ANG_W-1:0]     position,
  input  logic                                  last_in_group,
  input  jsrl_pkg::ctrl_cmd_t                   cmd,
  output jsrl_pkg::ctrl_sts_t                   sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [jsrl_pkg::JOINT_W-1:0]          out_joint,
  output logic signed [jsrl_pkg::ANG_W-1:0]     out_command,
  output logic                                  out_tick_end
);

  localparam int AW = jsrl_pkg::ANG_W;
  localparam int DW = jsrl_pkg::DIFF_W;
  localparam int TW = jsrl_pkg::TICKS_W;
  localparam int MW = jsrl_pkg::MSTEP_W;
  localparam int SW = jsrl_pkg::STEP_W;
  localparam logic signed [DW-1:0] SAT_MAX = DW'((64'sd1 <<< (AW - 1)) - 1);
  localparam logic signed [DW-1:0] SAT_MIN = -(DW'(64'sd1 <<< (AW - 1)));

  logic signed [AW-1:0] goal_angle    [jsrl_pkg::JOINTS];
  logic signed [AW-1:0] command_angle [jsrl_pkg::JOINTS];
  logic [TW-1:0]        ticks_left;
  logic                 reload_armed;
  logic                 tick_open;
  logic [TW-1:0]        ticks_per_period;
  logic [MW-1:0]        step_limit;

  // job registers
  logic [jsrl_pkg::JOINT_W-1:0] job_joint;
  logic                         job_last;
  logic signed [AW-1:0]         cmd_base;
  logic                         neg;
  logic [DW-1:0]                quo;
  logic [TW-1:0]                rem;
  logic [TW-1:0]                divisor;
  logic                         div_zero;
  logic signed [SW-1:0]         step;

  // item decode
  logic                 is_tick, is_goal, is_start, jvalid;
  logic [TW-1:0]        tl_eff;
  logic signed [AW-1:0] goal_rd, cmd_rd;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;

  assign is_goal  = (func == jsrl_pkg::FUNC_GOAL);
  assign is_start = (func == jsrl_pkg::FUNC_START);
  assign is_tick  = (func == jsrl_pkg::FUNC_TICK) || is_start;
  assign jvalid   = (32'(joint) < jsrl_pkg::JOINTS);

  always_comb begin
    goal_rd = '0;
    cmd_rd  = '0;
    if (jvalid) begin
      goal_rd = goal_angle[joint];
      cmd_rd  = command_angle[joint];
    end
  end

  always_comb begin
    tl_eff = ticks_left;
    if (!tick_open) begin
      if (reload_armed) tl_eff = ticks_per_period;
      else if (is_start) tl_eff = '0;
    end
  end

  // a start tick seeds goal from the measurement, so d is zero
  assign diff = is_start ? '0 : (DW'(goal_rd) - DW'(position));
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

  assign sts.launch   = is_tick && jvalid;
  assign sts.div_zero = div_zero;
  assign sts.out_free = !out_valid || out_ready;

  // restoring divide, one quotient bit a cycle
  logic [TW:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem, quo[DW-1]};
  assign rem_ge = (rem_sh >= {1'b0, divisor});

  // clamp and saturating add
  logic [MW-1:0]        mag_c;
  logic signed [DW-1:0] sum;
  logic signed [AW-1:0] sat_sum;
  assign mag_c = (quo > DW'(step_limit)) ? step_limit : MW'(quo);
  assign sum   = DW'(cmd_base) + DW'(step);
  always_comb begin
    priority if (sum > SAT_MAX) sat_sum = AW'(SAT_MAX);
    else if (sum < SAT_MIN)     sat_sum = AW'(SAT_MIN);
    else                        sat_sum = AW'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jsrl_pkg::JOINTS; i++) begin
        goal_angle[i]    <= '0;
        command_angle[i] <= '0;
      end
      ticks_left       <= '0;
      reload_armed     <= 1'b0;
      tick_open        <= 1'b0;
      ticks_per_period <= jsrl_pkg::TICKS_RESET;
      step_limit       <= jsrl_pkg::MSTEP_RESET;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jsrl_pkg::REG_TICKS_PER_PERIOD: ticks_per_period <= cfg_data[TW-1:0];
          jsrl_pkg::REG_STEP_LIMIT:       step_limit <= cfg_data[MW-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        if (is_goal && last_in_group) reload_armed <= 1'b1;
        if (is_tick) begin
          if (!tick_open && reload_armed) reload_armed <= 1'b0;
          tick_open <= !last_in_group;
          if (last_in_group) ticks_left <= (tl_eff != '0) ? tl_eff - 1'b1 : '0;
          else               ticks_left <= tl_eff;
        end
        if (jvalid && (is_goal || is_start)) goal_angle[joint] <= position;
      end

      if (cmd.apply) begin
        command_angle[job_joint] <= sat_sum;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      job_joint <= joint;
      job_last  <= last_in_group;
      cmd_base  <= is_start ? position : cmd_rd;
      neg       <= diff[DW-1];
      quo       <= mag;
      rem       <= '0;
      divisor   <= tl_eff;
      div_zero  <= (tl_eff == '0);
    end
    if (cmd.div_step) begin
      quo <= {quo[DW-2:0], rem_ge};
      rem <= rem_ge ? TW'(rem_sh - {1'b0, divisor}) : rem_sh[TW-1:0];
    end
    if (cmd.clamp) begin
      step <= neg ? -SW'(mag_c) : SW'(mag_c);
    end
    if (cmd.apply) begin
      out_joint    <= job_joint;
      out_command  <= sat_sum;
      out_tick_end <= job_last;
    end
  end

endmodule

// ===== src/joint_setpoint_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// joint_setpoint_rate_limiter
// Spreads each joint's goal over a period of control ticks and limits the
// per-tick change of the commanded angle.
//
//   channel     direction  handshake     payload
//   item_in     in         valid/ready   func, joint, position, last_in_group
//   result_out  out        valid/ready   out_joint, command, tick_end
//   cfg         in         cfg_we        cfg_index, cfg_data
//
// A goal item, an unused code or a tick item for an out-of-range joint is taken
// without a divide. A tick item for a joint runs accept, 29 steps of the
// bit-serial divider, clamp, apply; with no ticks left the divider is skipped.
// Reset is synchronous and loads the register defaults; stores clear at once.
// The result waits in an output register, so the next item is taken while
// it stalls; a second result holds in the apply step until the first leaves.
// ----------------------------------------------------------------------------
module joint_setpoint_rate_limiter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [jsrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jsrl_pkg::CFG_DATA_W-1:0]   cfg_data,
  jsrl_in_if.sink                           item_in,
  jsrl_out_if.source                        result_out
);

  jsrl_pkg::ctrl_cmd_t cmd;
  jsrl_pkg::ctrl_sts_t sts;

  jsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jsrl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (item_in.func),
    .joint         (item_in.joint),
    .position      (item_in.position),
    .last_in_group (item_in.last_in_group),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .out_joint     (result_out.out_joint),
    .out_command   (result_out.command),
    .out_tick_end  (result_out.tick_end)
  );

  // a result is written only into a free output register
  a_apply_free: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> sts.out_free)
    else $error("result applied while output register busy");

  // an item that starts a divide closes the input until it is applied
  a_launch_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && sts.launch) |=> !item_in.ready)
    else $error("input open during divide");

  a_apply_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> result_out.valid)
    else $error("applied result not presented");

endmodule

// ===== tb/sv/tb_joint_setpoint_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// tb_joint_setpoint_rate_limiter
// Self-checking bench for the joint setpoint rate limiter. A clocked driver
// sends goal sets, control ticks and noise items from a queue. It keeps a
// software copy of the goal/command stores and the period counter. A clocked
// monitor checks every command transfer against the oldest predicted one.
// Both channels idle in random bursts. Register settings change between
// phases, including the extremes of both registers.
// ----------------------------------------------------------------------------
module tb_joint_setpoint_rate_limiter;
  import jsrl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [ANG_W-1:0] ANG_TOP    = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_BOTTOM = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic [MSTEP_W-1:0] MSTEP_ALL = {MSTEP_W{1'b1}};
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 52;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [JOINT_W-1:0]       joint;
    logic signed [ANG_W-1:0]  position;
    logic                     last;
  } joint_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic signed [ANG_W-1:0]  command;
    logic                     tick_end;
  } joint_cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jsrl_in_if  item_if ();
  jsrl_out_if res_if ();

  joint_setpoint_rate_limiter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_if),
    .result_out (res_if)
  );

  // software copy of the block state
  logic signed [ANG_W-1:0] goal_ang [JOINTS];
  logic signed [ANG_W-1:0] cmd_ang  [JOINTS];
  logic [TICKS_W-1:0] ticks_left;
  logic               reload_armed;
  logic               in_tick;
  logic [TICKS_W-1:0] period_ticks;
  logic [MSTEP_W-1:0] step_limit;

  joint_item_t stim_q [$];
  joint_cmd_t  cmd_due_q [$];
  joint_item_t cur_item;
  joint_cmd_t  due;
  int          n_items;
  int          n_bad;
  logic        calm;
  logic [2:0]  gap_left;
  logic [2:0]  stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic advance_setpoints(input joint_item_t it);
    longint diff, step, lim, sum;
    int j;
    logic in_range;
    j = int'(it.joint);
    in_range = (j < JOINTS);
    if (it.func == FUNC_GOAL) begin
      if (in_range) goal_ang[j] = it.position;
      if (it.last) reload_armed = 1'b1;
    end else if (it.func == FUNC_TICK || it.func == FUNC_START) begin
      if (!in_tick) begin
        if (it.func == FUNC_START) ticks_left = '0;
        if (reload_armed) begin
          ticks_left = period_ticks;
          reload_armed = 1'b0;
        end
        in_tick = 1'b1;
      end
      if (in_range) begin
        if (it.func == FUNC_START) begin
          cmd_ang[j] = it.position;
          goal_ang[j] = it.position;
        end
        diff = longint'($signed(goal_ang[j])) - longint'($signed(it.position));
        step = (ticks_left != 0) ? diff / longint'(ticks_left) : diff;
        lim = longint'(step_limit);
        if (step > lim) step = lim;
        if (step < -lim) step = -lim;
        sum = longint'($signed(cmd_ang[j])) + step;
        if (sum > longint'(ANG_TOP)) sum = longint'(ANG_TOP);
        if (sum < longint'(ANG_BOTTOM)) sum = longint'(ANG_BOTTOM);
        cmd_ang[j] = sum[ANG_W-1:0];
        cmd_due_q.push_back('{joint: it.joint, command: cmd_ang[j], tick_end: it.last});
      end
      if (it.last) begin
        if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
        in_tick = 1'b0;
      end
    end
  endtask

  // driver: hold the item until its transfer, then maybe idle a burst
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
      gap_left <= '0;
    end else begin
      if (item_if.valid && item_if.ready) advance_setpoints(cur_item);
      if (item_if.valid && !item_if.ready) begin
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1'b1;
        item_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap_left <= 3'($urandom_range(0, 6));
        item_if.valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        cur_item = stim_q.pop_front();
        item_if.func <= cur_item.func;
        item_if.joint <= cur_item.joint;
        item_if.position <= cur_item.position;
        item_if.last_in_group <= cur_item.last;
        item_if.valid <= 1'b1;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // monitor: check each command transfer, stall ready in bursts
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left <= '0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (cmd_due_q.size() == 0) begin
          $error("command with none pending: joint %0d command %0d",
                 res_if.out_joint, $signed(res_if.command));
          n_bad++;
        end else begin
          due = cmd_due_q.pop_front();
          if (res_if.out_joint !== due.joint) begin
            $error("out_joint: expected %0d, actual %0d", due.joint, res_if.out_joint);
            n_bad++;
          end
          if (res_if.command !== due.command) begin
            $error("command: expected %0d, actual %0d",
                   $signed(due.command), $signed(res_if.command));
            n_bad++;
          end
          if (res_if.tick_end !== due.tick_end) begin
            $error("tick_end: expected %0d, actual %0d", due.tick_end, res_if.tick_end);
            n_bad++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1'b1;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= 3'($urandom_range(0, 6));
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [ANG_W-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: pick_angle = ANG_TOP;
      1: pick_angle = ANG_BOTTOM;
      2, 3: pick_angle = ANG_W'($urandom);
      default: pick_angle = ANG_W'($urandom_range(0, 32'h1FFFFF)) - ANG_W'(32'h100000);
    endcase
  endfunction

  function automatic logic [MSTEP_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: pick_limit = '0;
      1: pick_limit = MSTEP_W'($urandom_range(1, 32'hFFFF));
      2: pick_limit = MSTEP_RESET;
      3: pick_limit = MSTEP_W'(32'h1000000);
      4: pick_limit = MSTEP_ALL;
      default: pick_limit = MSTEP_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [FUNC_W-1:0] f, input logic [JOINT_W-1:0] j,
                            input logic signed [ANG_W-1:0] p, input logic l);
    stim_q.push_back('{func: f, joint: j, position: p, last: l});
    if (f != FUNC_UNUSED) n_items++;
  endtask

  task automatic goal_group();
    int count;
    count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, JOINTS) : JOINTS;
    for (int j = 0; j < count; j++)
      queue_item(FUNC_GOAL, JOINT_W'(j), pick_angle(), j == count - 1);
  endtask

  task automatic tick_group(input logic [FUNC_W-1:0] f);
    for (int j = 0; j < JOINTS; j++)
      queue_item(f, JOINT_W'(j), pick_angle(), j == JOINTS - 1);
  endtask

  // broken tick: no closing item, so the next tick continues it
  task automatic partial_tick();
    int count;
    count = $urandom_range(1, JOINTS - 1);
    for (int j = 0; j < count; j++)
      queue_item(FUNC_TICK, JOINT_W'($urandom_range(0, JOINTS)), pick_angle(), 1'b0);
  endtask

  task automatic random_phase(input int quota);
    int stop_at;
    stop_at = n_items + quota;
    tick_group(FUNC_START);
    while (n_items < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2: goal_group();
        3: tick_group(FUNC_START);
        4, 5: queue_item(FUNC_W'($urandom_range(0, 3)), JOINT_W'($urandom_range(0, 7)),
                         pick_angle(), 1'($urandom_range(0, 1)));
        6: partial_tick();
        default: tick_group(FUNC_TICK);
      endcase
    end
  endtask

  // wait out every pending item and command, then let the datapath settle
  task automatic drain();
    while (stim_q.size() != 0 || item_if.valid || cmd_due_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [TICKS_W-1:0] tpp, input logic [MSTEP_W-1:0] lim);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_TICKS_PER_PERIOD;
    cfg_data <= CFG_DATA_W'(tpp);
    @(posedge clk);
    cfg_index <= REG_STEP_LIMIT;
    cfg_data <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    period_ticks = tpp;
    step_limit = lim;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_if.valid = 1'b0;
    item_if.func = '0;
    item_if.joint = '0;
    item_if.position = '0;
    item_if.last_in_group = 1'b0;
    res_if.ready = 1'b0;
    calm = 1'b0;
    n_items = 0;
    n_bad = 0;
    for (int j = 0; j < JOINTS; j++) begin
      goal_ang[j] = '0;
      cmd_ang[j] = '0;
    end
    ticks_left = '0;
    reload_armed = 1'b0;
    in_tick = 1'b0;
    period_ticks = TICKS_RESET;
    step_limit = MSTEP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every code, out-of-range joint, goals inside a tick
    queue_item(FUNC_GOAL, 3'd0, ANG_TOP, 1'b0);
    queue_item(FUNC_GOAL, 3'd6, ANG_BOTTOM, 1'b0);
    queue_item(FUNC_GOAL, 3'd7, ANG_W'(32'h5555555), 1'b1);
    queue_item(FUNC_START, 3'd0, '0, 1'b0);
    queue_item(FUNC_TICK, 3'd6, ANG_TOP, 1'b0);
    queue_item(FUNC_TICK, 3'd7, ANG_BOTTOM, 1'b1);
    queue_item(FUNC_UNUSED, 3'd5, '1, 1'b1);
    queue_item(FUNC_TICK, 3'd0, ANG_BOTTOM, 1'b0);
    queue_item(FUNC_TICK, 3'd6, ANG_TOP, 1'b1);
    queue_item(FUNC_TICK, 3'd1, '1, 1'b0);
    queue_item(FUNC_GOAL, 3'd1, ANG_W'(32'h0ABCDEF), 1'b1);
    queue_item(FUNC_TICK, 3'd2, ANG_W'(32'h2AAAAAA), 1'b1);
    queue_item(FUNC_TICK, 3'd1, '0, 1'b0);
    queue_item(FUNC_TICK, 3'd7, '0, 1'b0);
    queue_item(FUNC_TICK, 3'd0, ANG_W'(32'h7000000), 1'b1);
    queue_item(FUNC_START, 3'd6, ANG_BOTTOM, 1'b0);
    queue_item(FUNC_START, 3'd0, ANG_TOP, 1'b1);
    queue_item(FUNC_TICK, 3'd0, ANG_BOTTOM, 1'b1);
    drain();

    apply_setting(TICKS_W'(1), '0);
    random_phase(PHASE_ITEMS);
    drain();
    apply_setting('0, MSTEP_ALL);
    random_phase(PHASE_ITEMS);
    drain();
    apply_setting(TICKS_W'(1000), MSTEP_W'(32'h1000000));
    random_phase(PHASE_ITEMS);
    drain();
    apply_setting('1, pick_limit());
    random_phase(PHASE_ITEMS);
    drain();
    for (int p = 0; p < 2; p++) begin
      apply_setting(TICKS_W'($urandom_range(1, 12)), pick_limit());
      random_phase(PHASE_ITEMS);
      drain();
    end
    // final stretch runs without idling on either side
    calm = 1'b1;
    apply_setting(TICKS_W'($urandom_range(1, 40)), MSTEP_RESET);
    random_phase(PHASE_ITEMS);
    drain();

    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
